// ===== hw/rtl/fce_pkg.sv =====
// Shared constants and types for the FIR convolve/correlate block.
package fce_pkg;

    localparam int OUT_W     = 36;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 16;
    localparam int CNT_W     = 17;
    localparam int KLEN_W    = 5;
    localparam int KLEN_MAX  = 16;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEN = 2'd3;

    typedef enum logic [1:0] {
        TRIM_FULL  = 2'd0,
        TRIM_SAME  = 2'd1,
        TRIM_VALID = 2'd2
    } trim_t;

    typedef struct packed {
        logic              step;
        logic              clear;
        logic              load;
        logic [SLOT_W-1:0] slot;
    } cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

// ===== hw/rtl/fce_cell.sv =====
// One tap cell: sample delay stage, coefficient register and tap multiplier.
module fce_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX       = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fce_pkg::cell_ctrl_t             ctrl,
    input  logic signed [SAMPLE_BITS-1:0]   load_word,
    input  logic signed [SAMPLE_BITS-1:0]   sample_in,
    input  logic signed [SAMPLE_BITS-1:0]   coef_in,
    output logic signed [SAMPLE_BITS-1:0]   sample_out,
    output logic signed [SAMPLE_BITS-1:0]   coef_out,
    output logic signed [2*SAMPLE_BITS-1:0] product
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic signed [SAMPLE_BITS-1:0] coef_reg;
    logic signed [SAMPLE_BITS-1:0] coef_next;
    logic                          slot_hit;

    assign slot_hit = ctrl.load && (int'(ctrl.slot) == INDEX);

    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.clear)
        begin
            sample_next = '0;
        end
        else if (ctrl.step)
        begin
            sample_next = sample_in;
        end
    end

    assign coef_next = slot_hit ? load_word : coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    // multiply the sample as it stands after this step's shift
    assign product    = sample_in * coef_in;
    assign sample_out = sample_reg;
    assign coef_out   = coef_reg;

endmodule

// ===== hw/rtl/fce_sum_tree.sv =====
// Registered adder tree that sums the tap products, with a matching tag pipe.
module fce_sum_tree #(
    parameter int N    = 16,
    parameter int W_IN = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           adv,
    input  logic signed [W_IN-1:0]                         terms [N],
    input  fce_pkg::tag_t                                  tag_in,
    output logic signed [W_IN+((N > 1) ? $clog2(N) : 0)-1:0] sum,
    output fce_pkg::tag_t                                  tag_out
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 0;
    localparam int NP     = 1 << LEVELS;
    localparam int SW     = W_IN + LEVELS;

    logic signed [SW-1:0] node_reg [0:LEVELS][0:NP-1];
    fce_pkg::tag_t        tag_reg  [0:LEVELS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                node_reg[0][i] <= SW'(terms[i]);
            end
            for (int i = N; i < NP; i++)
            begin
                node_reg[0][i] <= '0;
            end
            for (int l = 1; l <= LEVELS; l++)
            begin
                for (int i = 0; i < (NP >> l); i++)
                begin
                    node_reg[l][i] <= node_reg[l-1][2*i] + node_reg[l-1][2*i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l <= LEVELS; l++)
            begin
                tag_reg[l] <= '0;
            end
        end
        else if (adv)
        begin
            tag_reg[0] <= tag_in;
            for (int l = 1; l <= LEVELS; l++)
            begin
                tag_reg[l] <= tag_reg[l-1];
            end
        end
    end

    assign sum     = node_reg[LEVELS][0];
    assign tag_out = tag_reg[LEVELS];

endmodule

// ===== hw/rtl/fir_convolve_correlate_top.sv =====
// Top level of the streaming FIR convolve/correlate block.
//
// Input channel (item_valid/item_ready) carries one word per handshake: cmd 0
// loads data_word into kernel slot tap_slot, cmd 1 feeds one signal sample.
// Output channel (result_valid/result_ready) returns filter_sum, the exact
// Q6.30 sum of products, with end_of_job set on the last word of the job.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// Throughput: one input word per cycle while the output is not stalled. The
// sample that ends a job holds off the input while the tail is flushed through
// the cell chain with zero input, one flush step per unstalled cycle.
// Pipeline: the tap products are registered at the edge that accepts their
// word, then the clog2(TAPS) adder tree stages and the output register follow.
// Reset: configuration returns to full trim, convolution, lengths of one;
// sample history and job counters clear. Kernel slots hold nothing valid
// until loaded.
// Stall: while a result waits on result_ready, the whole pipe holds and
// item_ready drops; nothing is lost or repeated.
module fir_convolve_correlate_top #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fce_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fce_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 cmd,
    input  logic [fce_pkg::SLOT_W-1:0]           tap_slot,
    input  logic signed [SAMPLE_BITS-1:0]        data_word,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [fce_pkg::OUT_W-1:0]     filter_sum,
    output logic                                 end_of_job
);

    localparam int KMAX    = (TAPS < fce_pkg::KLEN_MAX) ? TAPS : fce_pkg::KLEN_MAX;
    localparam int LV_W    = $clog2(KMAX + 1);
    localparam int LEVELS  = (TAPS > 1) ? $clog2(TAPS) : 0;
    localparam int SUM_W   = 2*SAMPLE_BITS + LEVELS;
    localparam int SHIFT_W = $clog2(KMAX*SAMPLE_BITS + 1);
    localparam int LEN_W   = fce_pkg::LEN_W;
    localparam int CNT_W   = fce_pkg::CNT_W;
    localparam int KLEN_W  = fce_pkg::KLEN_W;
    localparam int OUT_W   = fce_pkg::OUT_W;
    localparam logic [LV_W-1:0]   KMAX_LV = LV_W'(KMAX);
    localparam logic [KLEN_W-1:0] KMAX_KL = KLEN_W'(KMAX);

    // configuration registers
    fce_pkg::trim_t    trim_mode_reg;
    logic              reverse_reg;
    logic [LEN_W-1:0]  sig_len_reg;
    logic [KLEN_W-1:0] ker_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_mode_reg <= fce_pkg::TRIM_FULL;
            reverse_reg   <= 1'b0;
            sig_len_reg   <= LEN_W'(1);
            ker_len_reg   <= KLEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fce_pkg::CFG_TRIM_MODE:  trim_mode_reg <= fce_pkg::trim_t'(cfg_data[1:0]);
                fce_pkg::CFG_REVERSE:    reverse_reg   <= cfg_data[0];
                fce_pkg::CFG_SIGNAL_LEN: sig_len_reg   <= cfg_data[LEN_W-1:0];
                fce_pkg::CFG_KERNEL_LEN: ker_len_reg   <= cfg_data[KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective lengths and the trimmed output window
    logic [LEN_W-1:0]  la;
    logic [KLEN_W-1:0] lv_kl;
    logic [LV_W-1:0]   lv;
    logic [LEN_W-1:0]  lv_ext;
    logic [LEN_W-1:0]  long_len;
    logic [LEN_W-1:0]  short_len;
    logic [LEN_W-1:0]  start_idx;
    logic [CNT_W-1:0]  job_len;

    assign la = (sig_len_reg == '0) ? LEN_W'(1) : sig_len_reg;

    always_comb
    begin
        lv_kl = ker_len_reg;
        if (ker_len_reg == '0)
        begin
            lv_kl = KLEN_W'(1);
        end
        else if (ker_len_reg > KMAX_KL)
        begin
            lv_kl = KMAX_KL;
        end
    end

    assign lv        = LV_W'(lv_kl);
    assign lv_ext    = LEN_W'(lv);
    assign long_len  = (la > lv_ext) ? la : lv_ext;
    assign short_len = (la > lv_ext) ? lv_ext : la;

    always_comb
    begin
        unique case (trim_mode_reg)
            fce_pkg::TRIM_SAME:
            begin
                start_idx = (short_len - LEN_W'(1)) >> 1;
                job_len   = CNT_W'(long_len);
            end
            fce_pkg::TRIM_VALID:
            begin
                start_idx = short_len - LEN_W'(1);
                job_len   = CNT_W'(long_len - short_len) + CNT_W'(1);
            end
            default:
            begin
                start_idx = '0;
                job_len   = CNT_W'(la) + CNT_W'(lv) - CNT_W'(1);
            end
        endcase
    end

    // job control
    logic             out_valid_reg;
    logic             adv;
    logic             flushing;
    logic             acc;
    logic             samp;
    logic             load;
    logic             flush_step;
    logic             step;
    logic             last_sample;
    logic             job_done;
    logic             emit;
    logic             last_out;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] made_reg;
    logic [CNT_W-1:0] made_next;
    logic [LV_W-1:0]  flush_reg;
    logic [LV_W-1:0]  flush_next;

    assign adv         = !out_valid_reg || result_ready;
    assign flushing    = (flush_reg != '0);
    assign item_ready  = adv && !flushing;
    assign acc         = item_valid && item_ready;
    assign samp        = acc && (cmd == fce_pkg::CMD_SAMPLE);
    assign load        = acc && (cmd == fce_pkg::CMD_LOAD);
    assign flush_step  = adv && flushing;
    assign step        = samp || flush_step;
    assign last_sample = samp && ((idx_reg + CNT_W'(1)) >= CNT_W'(la));
    assign job_done    = (last_sample && (lv == LV_W'(1)))
                      || (flush_step && (flush_reg == LV_W'(1)));
    assign emit        = step && (idx_reg >= CNT_W'(start_idx)) && (made_reg < job_len);
    assign last_out    = ((made_reg + CNT_W'(1)) == job_len);

    always_comb
    begin
        idx_next   = idx_reg;
        made_next  = made_reg;
        flush_next = flush_reg;
        if (step)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (emit)
            begin
                made_next = made_reg + CNT_W'(1);
            end
        end
        if (last_sample)
        begin
            flush_next = lv - LV_W'(1);
        end
        else if (flush_step)
        begin
            flush_next = flush_reg - LV_W'(1);
        end
        // drop all job state once the tail is out
        if (job_done)
        begin
            idx_next   = '0;
            made_next  = '0;
            flush_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            made_reg  <= '0;
            flush_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            made_reg  <= made_next;
            flush_reg <= flush_next;
        end
    end

    // cell chain
    fce_pkg::cell_ctrl_t           cell_ctrl;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] chain    [0:TAPS-1];
    logic signed [SAMPLE_BITS-1:0] coef_q   [0:TAPS-1];
    logic signed [SAMPLE_BITS-1:0] coef_eff [0:TAPS-1];
    logic signed [2*SAMPLE_BITS-1:0] products [TAPS];
    logic [KMAX*SAMPLE_BITS-1:0]   coef_rev;
    logic [KMAX*SAMPLE_BITS-1:0]   coef_shift;
    logic [SHIFT_W-1:0]            rev_shift;

    assign x_in      = flush_step ? '0 : data_word;
    assign cell_ctrl = '{step: step, clear: job_done, load: load, slot: tap_slot};
    assign chain[0]  = x_in;

    // reversed kernel: lay slots out backward, then slide by the unused taps
    assign rev_shift  = SHIFT_W'(KMAX_LV - lv) * SHIFT_W'(SAMPLE_BITS);
    assign coef_shift = coef_rev >> rev_shift;

    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        if (j < KMAX)
        begin : g_coef
            assign coef_rev[j*SAMPLE_BITS +: SAMPLE_BITS] = coef_q[KMAX-1-j];
            assign coef_eff[j] = (LV_W'(j) < lv)
                ? (reverse_reg ? coef_shift[j*SAMPLE_BITS +: SAMPLE_BITS] : coef_q[j])
                : '0;
        end
        else
        begin : g_nocoef
            assign coef_eff[j] = '0;
        end

        if (j < TAPS-1)
        begin : g_mid
            fce_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .INDEX       (j)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .load_word  (data_word),
                .sample_in  (chain[j]),
                .coef_in    (coef_eff[j]),
                .sample_out (chain[j+1]),
                .coef_out   (coef_q[j]),
                .product    (products[j])
            );
        end
        else
        begin : g_end
            fce_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .INDEX       (j)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .load_word  (data_word),
                .sample_in  (chain[j]),
                .coef_in    (coef_eff[j]),
                .sample_out (),
                .coef_out   (coef_q[j]),
                .product    (products[j])
            );
        end
    end

    // adder tree
    fce_pkg::tag_t          tag_in;
    fce_pkg::tag_t          tree_tag;
    logic signed [SUM_W-1:0] tree_sum;

    assign tag_in = '{valid: emit, last: last_out};

    fce_sum_tree #(
        .N    (TAPS),
        .W_IN (2*SAMPLE_BITS)
    ) u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .terms   (products),
        .tag_in  (tag_in),
        .sum     (tree_sum),
        .tag_out (tree_tag)
    );

    // saturate to the result width
    logic signed [OUT_W-1:0] sat_sum;

    if (SUM_W > OUT_W)
    begin : g_sat
        localparam int TOP_W = SUM_W - OUT_W + 1;
        logic [TOP_W-1:0] top_bits;

        assign top_bits = tree_sum[SUM_W-1:OUT_W-1];

        always_comb
        begin
            if ((top_bits == '0) || (top_bits == '1))
            begin
                sat_sum = tree_sum[OUT_W-1:0];
            end
            else if (tree_sum[SUM_W-1])
            begin
                sat_sum = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                sat_sum = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end
    else
    begin : g_ext
        assign sat_sum = OUT_W'(tree_sum);
    end

    // output register
    logic signed [OUT_W-1:0] sum_out_reg;
    logic                    eoj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tree_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_out_reg <= sat_sum;
            eoj_reg     <= tree_tag.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign filter_sum   = sum_out_reg;
    assign end_of_job   = eoj_reg;

    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        flushing |-> !item_ready)
        else $error("input taken during tail flush");

    a_flush_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (flushing && adv) |=> (flush_reg == ($past(flush_reg) - LV_W'(1))))
        else $error("flush counter skipped a step");

    a_job_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> ((idx_reg == '0) && (made_reg == '0) && (flush_reg == '0)))
        else $error("job state not cleared at end of job");

    a_stall_freezes_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (flushing && !adv) |=> $stable(flush_reg) && $stable(made_reg))
        else $error("flush advanced while output stalled");

endmodule

// ===== tb/fir_convolve_correlate_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming FIR convolve/correlate top level.
module fir_convolve_correlate_top_tb;

    localparam int SAMPLE_BITS   = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int HANG_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int CFG_IDX_W     = fce_pkg::CFG_IDX_W;
    localparam int CFG_W         = fce_pkg::CFG_W;
    localparam int SLOT_W        = fce_pkg::SLOT_W;
    localparam int OUT_W         = fce_pkg::OUT_W;
    localparam int LEN_W         = fce_pkg::LEN_W;
    localparam int KLEN_W        = fce_pkg::KLEN_W;
    localparam int KLEN_MAX      = fce_pkg::KLEN_MAX;
    localparam logic [1:0] TRIM_SPARE = 2'd3;

    typedef enum logic { ROW_REG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic [CFG_IDX_W-1:0]          reg_idx;
        logic [CFG_W-1:0]              reg_val;
        logic                          op;
        logic [SLOT_W-1:0]             slot;
        logic signed [SAMPLE_BITS-1:0] word;
        logic                          known;
        logic signed [OUT_W-1:0]       known_total;
    } dir_row_t;

    typedef struct {
        logic signed [OUT_W-1:0] total;
        logic                    last;
    } conv_result_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_W-1:0]              cfg_data     = '0;
    logic                          item_valid   = 1'b0;
    logic                          item_ready;
    logic                          cmd          = fce_pkg::CMD_LOAD;
    logic [SLOT_W-1:0]             tap_slot     = '0;
    logic signed [SAMPLE_BITS-1:0] data_word    = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic signed [OUT_W-1:0]       filter_sum;
    logic                          end_of_job;

    // Predictor state: kernel, sample history (index 0 newest), job counters
    logic signed [SAMPLE_BITS-1:0] coef_mem [KLEN_MAX];
    logic signed [SAMPLE_BITS-1:0] history [KLEN_MAX] = '{default: '0};
    logic [1:0]                    trim_code    = fce_pkg::TRIM_FULL;
    logic                          reverse_on   = 1'b0;
    logic [LEN_W-1:0]              signal_len   = 1;
    logic [KLEN_W-1:0]             kernel_len   = 1;
    int unsigned                   samples_taken = 0;
    int unsigned                   sums_made     = 0;
    conv_result_t                  pending_sums[$];
    dir_row_t                      dir_rows[$];

    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   words_sent  = 0;
    int   stall_left  = 0;
    int   mode_left   = 0;
    logic quiet_in    = 1'b0;
    logic quiet_out   = 1'b0;

    fir_convolve_correlate_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .tap_slot     (tap_slot),
        .data_word    (data_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filter_sum   (filter_sum),
        .end_of_job   (end_of_job)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Directed table rows: a register write, or an input word
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        dir_row_t r;
        r.kind        = ROW_REG;
        r.reg_idx     = idx;
        r.reg_val     = val;
        r.op          = fce_pkg::CMD_LOAD;
        r.slot        = '0;
        r.word        = '0;
        r.known       = 1'b0;
        r.known_total = '0;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void add_word(input logic op, input logic [SLOT_W-1:0] slot,
                                     input logic signed [SAMPLE_BITS-1:0] word,
                                     input logic known = 1'b0,
                                     input logic signed [OUT_W-1:0] known_total = '0);
        dir_row_t r;
        r.kind        = ROW_WORD;
        r.reg_idx     = fce_pkg::CFG_TRIM_MODE;
        r.reg_val     = '0;
        r.op          = op;
        r.slot        = slot;
        r.word        = word;
        r.known       = known;
        r.known_total = known_total;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic longint tap_total(int unsigned taps);
        longint                        acc;
        logic signed [SAMPLE_BITS-1:0] c;
        int unsigned                   j;
        acc = 0;
        for (j = 0; j < taps; j++)
        begin
            c = reverse_on ? coef_mem[taps - 1 - j] : coef_mem[j];
            acc += longint'(history[j]) * longint'(c);
        end
        return acc;
    endfunction

    function automatic void shift_history(logic signed [SAMPLE_BITS-1:0] x);
        int i;
        for (i = KLEN_MAX - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = x;
    endfunction

    // Queue one output term if it lies inside the trimmed window
    function automatic void post_sum(int unsigned idx, int unsigned start,
                                     int unsigned len, int unsigned taps);
        conv_result_t r;
        longint       acc;
        if (idx < start || sums_made >= len)
            return;
        acc = tap_total(taps);
        sums_made++;
        r.total = acc[OUT_W-1:0];
        r.last  = (sums_made == len);
        pending_sums.insert(pending_sums.size(), r);
    endfunction

    function automatic void convolve_sample(logic signed [SAMPLE_BITS-1:0] x);
        int unsigned la, lv, big, sml, start, len, n, t;
        la  = (signal_len == 0) ? 1 : signal_len;
        lv  = (kernel_len == 0) ? 1 : ((kernel_len > KLEN_MAX) ? KLEN_MAX : kernel_len);
        big = (la > lv) ? la : lv;
        sml = (la > lv) ? lv : la;
        if (trim_code == fce_pkg::TRIM_SAME)
        begin
            start = (sml - 1) / 2;
            len   = big;
        end
        else if (trim_code == fce_pkg::TRIM_VALID)
        begin
            start = sml - 1;
            len   = big - sml + 1;
        end
        else
        begin
            start = 0;
            len   = la + lv - 1;
        end
        n = samples_taken;
        shift_history(x);
        post_sum(n, start, len, lv);
        if (n + 1 >= la)
        begin
            // last sample: flush the tail with zeros, then clear job state
            for (t = 1; t < lv; t++)
            begin
                shift_history('0);
                post_sum(n + t, start, len, lv);
            end
            history       = '{default: '0};
            samples_taken = 0;
            sums_made     = 0;
        end
        else
            samples_taken = n + 1;
    endfunction

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            fce_pkg::CFG_TRIM_MODE:  trim_code  = val[1:0];
            fce_pkg::CFG_REVERSE:    reverse_on = val[0];
            fce_pkg::CFG_SIGNAL_LEN: signal_len = val[LEN_W-1:0];
            fce_pkg::CFG_KERNEL_LEN: kernel_len = val[KLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Drain every expected word, then hold off for flush steps that emit nothing
    task automatic wait_idle();
        cfg_we     <= 1'b0;
        item_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic signed [SAMPLE_BITS-1:0] word,
                             input logic known = 1'b0,
                             input logic signed [OUT_W-1:0] known_total = '0);
        int gap;
        gap = 0;
        if (!quiet_in)
        begin
            case ($urandom_range(0, 15))
                9, 10, 11, 12, 13: gap = $urandom_range(1, 3);
                14, 15:            gap = $urandom_range(8, 40);
                default:           gap = 0;
            endcase
        end
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= op;
        tap_slot   <= slot;
        data_word  <= word;
        do
            @(posedge clk);
        while (!item_ready);
        words_sent++;
        if (op == fce_pkg::CMD_LOAD)
            coef_mem[slot] = word;
        else
        begin
            convolve_sample(word);
            if (known)
            begin
                pending_sums[pending_sums.size() - 1].total = known_total;
                pending_sums[pending_sums.size() - 1].last  = 1'b1;
            end
        end
    endtask

    // Output side: check each accepted word, drive ready stalls, track progress
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (result_valid && result_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got %0d (end_of_job %0b)",
                             $time, filter_sum, end_of_job);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (filter_sum !== want.total)
                    begin
                        mismatches++;
                        $display("%0t: filter_sum mismatch, expected %0d, got %0d",
                                 $time, want.total, filter_sum);
                    end
                    if (end_of_job !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: end_of_job mismatch, expected %0b, got %0b",
                                 $time, want.last, end_of_job);
                    end
                end
            end

            if (mode_left == 0)
            begin
                mode_left = $urandom_range(40, 300);
                quiet_in  = ($urandom_range(0, 3) == 0);
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            else
                mode_left--;

            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!quiet_out)
                begin
                    case ($urandom_range(0, 15))
                        0, 1, 2: stall_left = $urandom_range(1, 3);
                        3:       stall_left = $urandom_range(8, 40);
                        default: ;
                    endcase
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        logic     in_cfg;
        int       goal, jobs, count, load_at, s, k, eff;

        // Single-tap, single-sample jobs after reset: extremes are read off directly
        add_word(fce_pkg::CMD_LOAD, 4'd0, 16'sh8000);
        add_word(fce_pkg::CMD_SAMPLE, 4'd15, 16'sh8000, 1'b1, 36'sd1073741824);
        add_word(fce_pkg::CMD_LOAD, 4'd0, 16'sh7fff);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sh8000, 1'b1, -36'sd1073709056);
        add_word(fce_pkg::CMD_SAMPLE, 4'd5, 16'sh7fff, 1'b1, 36'sd1073676289);
        // spare trim code and zero lengths all fall back to full, one tap, one sample
        add_reg(fce_pkg::CFG_TRIM_MODE, CFG_W'(TRIM_SPARE));
        add_reg(fce_pkg::CFG_KERNEL_LEN, '0);
        add_reg(fce_pkg::CFG_SIGNAL_LEN, '0);
        add_word(fce_pkg::CMD_SAMPLE, 4'd10, 16'sd1, 1'b1, 36'sd32767);
        add_word(fce_pkg::CMD_LOAD, 4'd15, -16'sd1);
        add_word(fce_pkg::CMD_LOAD, 4'd1, 16'sd16384);
        add_word(fce_pkg::CMD_LOAD, 4'd2, -16'sd12345);
        // three taps: full, then same with correlation, then valid
        add_reg(fce_pkg::CFG_TRIM_MODE, CFG_W'(fce_pkg::TRIM_FULL));
        add_reg(fce_pkg::CFG_KERNEL_LEN, 16'd3);
        add_reg(fce_pkg::CFG_SIGNAL_LEN, 16'd3);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sd1000);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, -16'sd2000);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sd30000);
        add_reg(fce_pkg::CFG_TRIM_MODE, CFG_W'(fce_pkg::TRIM_SAME));
        add_reg(fce_pkg::CFG_REVERSE, 16'd1);
        add_reg(fce_pkg::CFG_SIGNAL_LEN, 16'd2);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sh8000);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sh7fff);
        add_reg(fce_pkg::CFG_TRIM_MODE, CFG_W'(fce_pkg::TRIM_VALID));
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sd12345);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, -16'sd7);
        // longest job, a coefficient swap mid-job, then a shortened length ends it
        add_reg(fce_pkg::CFG_TRIM_MODE, CFG_W'(fce_pkg::TRIM_FULL));
        add_reg(fce_pkg::CFG_REVERSE, 16'd0);
        add_reg(fce_pkg::CFG_SIGNAL_LEN, 16'hffff);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sd500);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, -16'sd500);
        add_word(fce_pkg::CMD_LOAD, 4'd1, -16'sd1);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sd777);
        add_reg(fce_pkg::CFG_SIGNAL_LEN, 16'd2);
        add_word(fce_pkg::CMD_SAMPLE, 4'd0, 16'sh8000);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        in_cfg = 1'b0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_REG)
            begin
                if (!in_cfg)
                    wait_idle();
                in_cfg = 1'b1;
                write_cfg(row.reg_idx, row.reg_val);
            end
            else
            begin
                in_cfg = 1'b0;
                send_item(row.op, row.slot, row.word, row.known, row.known_total);
            end
        end

        // fill every slot so no job ever reads an unloaded tap
        for (k = 0; k < KLEN_MAX; k++)
            send_item(fce_pkg::CMD_LOAD, SLOT_W'(k), rand_word());

        goal = words_sent + RANDOM_ITEMS;
        while (words_sent < goal)
        begin
            wait_idle();
            write_cfg(fce_pkg::CFG_TRIM_MODE, CFG_W'($urandom_range(0, 3)));
            write_cfg(fce_pkg::CFG_REVERSE, CFG_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 19))
                0:       eff = 0;
                1:       eff = (1 << LEN_W) - 1;
                2, 3, 4: eff = $urandom_range(9, 40);
                default: eff = $urandom_range(1, 8);
            endcase
            write_cfg(fce_pkg::CFG_SIGNAL_LEN, CFG_W'(eff));
            case ($urandom_range(0, 9))
                0:       k = 0;
                1:       k = $urandom_range(KLEN_MAX + 1, (1 << KLEN_W) - 1);
                2, 3:    k = KLEN_MAX;
                default: k = $urandom_range(1, KLEN_MAX - 1);
            endcase
            write_cfg(fce_pkg::CFG_KERNEL_LEN, CFG_W'(k));
            if (eff == 0)
                eff = 1;

            jobs = $urandom_range(1, 3);
            repeat (jobs)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_item(fce_pkg::CMD_LOAD, SLOT_W'($urandom()), rand_word());
                // long jobs stay open; they end at a later sample once a shorter length is written
                if (eff > 40)
                    count = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    count = $urandom_range(1, eff);
                else
                    count = eff;
                load_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, count - 1)) : -1;
                for (s = 0; s < count; s++)
                begin
                    if (s == load_at)
                        send_item(fce_pkg::CMD_LOAD, SLOT_W'($urandom()), rand_word());
                    send_item(fce_pkg::CMD_SAMPLE, SLOT_W'($urandom()), rand_word());
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fce_pkg.sv
hw/rtl/fce_cell.sv
hw/rtl/fce_sum_tree.sv
hw/rtl/fir_convolve_correlate_top.sv
tb/fir_convolve_correlate_top_tb.sv
